// ----- rtl/q24_8_fixed_point_alu_top_assert.svh -----
// Assertion macros shared by the checker file.
`ifndef Q24_8_FIXED_POINT_ALU_TOP_ASSERT_SVH
`define Q24_8_FIXED_POINT_ALU_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define Q24_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("q24 alu check failed");

// Next-cycle implication, disabled during reset.
`define Q24_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("q24 alu check failed");

`endif

// ----- rtl/q24alu_pkg.sv -----
// Shared types and constants for the Q24.8 fixed-point ALU.
package q24alu_pkg;

  localparam int DATA_W        = 32;
  localparam int OP_W          = 4;
  localparam int FRAC_BITS_DEF = 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  // Sideband that rides along the divider stages.
  typedef struct packed {
    logic [DATA_W-1:0] res;     // finished result for non-divide ops
    logic              is_div;
    logic              neg;     // operand signs differ
    logic              dz;      // divide by zero
    logic              cmp;
  } div_tag_t;

endpackage

// ----- rtl/q24alu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage after the load stage, with sideband tag.
module q24alu_div #(
  parameter int FRACTION_BITS = q24alu_pkg::FRAC_BITS_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 en,
  input  logic                                                 in_valid,
  input  logic [q24alu_pkg::DATA_W+FRACTION_BITS-1:0]          dividend,
  input  logic [q24alu_pkg::DATA_W-1:0]                        divisor,
  input  q24alu_pkg::div_tag_t                                 in_tag,
  output logic                                                 out_valid,
  output logic [q24alu_pkg::DATA_W+FRACTION_BITS-1:0]          quotient,
  output q24alu_pkg::div_tag_t                                 out_tag
);
  import q24alu_pkg::*;

  localparam int QW = DATA_W + FRACTION_BITS;
  localparam int NS = QW + 1;

  logic [NS-1:0]     v_r;
  logic [QW-1:0]     num_r   [NS];
  logic [DATA_W-1:0] rem_r   [NS];
  logic [DATA_W-1:0] den_r   [NS];
  div_tag_t          tag_r   [NS];
  logic [QW-1:0]     num_nxt [NS];
  logic [DATA_W-1:0] rem_nxt [NS];
  logic [DATA_W:0]   trial   [NS];
  logic [DATA_W:0]   diff    [NS];
  logic [NS-1:0]     qbit;

  // Stage k holds the partial remainder after k quotient bits; num shifts the
  // dividend out at the top and the quotient in at the bottom.
  always_comb begin
    num_nxt[0] = dividend;
    rem_nxt[0] = '0;
    trial[0]   = '0;
    diff[0]    = '0;
    qbit[0]    = 1'b0;
    for (int k = 1; k < NS; k++) begin
      trial[k]   = {rem_r[k-1], num_r[k-1][QW-1]};
      diff[k]    = trial[k] - {1'b0, den_r[k-1]};
      qbit[k]    = ~diff[k][DATA_W];
      rem_nxt[k] = qbit[k] ? diff[k][DATA_W-1:0] : trial[k][DATA_W-1:0];
      num_nxt[k] = {num_r[k-1][QW-2:0], qbit[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= num_nxt[0];
      rem_r[0] <= rem_nxt[0];
      den_r[0] <= divisor;
      tag_r[0] <= in_tag;
      for (int k = 1; k < NS; k++) begin
        num_r[k] <= num_nxt[k];
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_r[k-1];
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign quotient  = num_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule

// ----- rtl/q24_8_fixed_point_alu_top.sv -----
// Q24.8 fixed-point ALU: top level with operand stages, divider and output register.
//
// Input channel in_*: opcode plus two raw signed operands, one beat per item.
// Output channel out_*: result value, compare flag and divide-by-zero flag,
// exactly one beat per input beat, in order.
// Path: an operand register, a stage for multiply / compare / magnitudes,
// FRACTION_BITS + 33 divider stages (a load stage, then one quotient bit
// per stage), and the output register.
// Every operation runs through the full divider chain so results stay ordered.
// Throughput is one beat per cycle while in_stall is low.
// Reset (rst_n low, synchronous) clears all valid bits; no result is pending
// afterwards.
// When out_stall holds a result in the output register, the pipeline keeps
// advancing until a finished result reaches its last stage; only then is
// in_stall raised and the whole pipe freezes, losing nothing.
module q24_8_fixed_point_alu_top #(
  parameter int FRACTION_BITS = q24alu_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [q24alu_pkg::OP_W-1:0]           in_opcode,
  input  logic signed [q24alu_pkg::DATA_W-1:0]  in_operand_a,
  input  logic signed [q24alu_pkg::DATA_W-1:0]  in_operand_b,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [q24alu_pkg::DATA_W-1:0]  out_result_value,
  output logic                                  out_compare_true,
  output logic                                  out_divide_error
);
  import q24alu_pkg::*;

  localparam int QW = DATA_W + FRACTION_BITS;

  logic                       en;
  logic                       rdy_out;

  // Operand stage
  logic                       va_r;
  op_t                        op_r;
  logic signed [DATA_W-1:0]   a_r;
  logic signed [DATA_W-1:0]   b_r;

  // Compute stage
  logic                       vb_r;
  logic signed [2*DATA_W-1:0] prod_nxt, prod_r;
  logic [DATA_W-1:0]          simple_nxt, simple_r;
  logic                       cmp_nxt, cmp_r;
  logic                       is_mul_nxt, is_mul_r;
  logic                       is_div_nxt, is_div_r;
  logic                       dz_nxt, dz_r;
  logic                       neg_nxt, neg_r;
  logic [DATA_W-1:0]          mag_a, mag_b;
  logic [QW-1:0]              dvd_nxt, dvd_r;
  logic [DATA_W-1:0]          dvs_r;

  // Divider boundary
  div_tag_t                   tag_in;
  div_tag_t                   tag_out;
  logic                       dv_out;
  logic [QW-1:0]              quot;
  logic [DATA_W-1:0]          q_lo;
  logic [DATA_W-1:0]          res_fin;

  // Output register
  logic                       out_valid_r;
  logic [DATA_W-1:0]          res_r;
  logic                       cmp_out_r;
  logic                       derr_r;

  assign rdy_out  = ~out_valid_r | ~out_stall;
  assign en       = rdy_out | ~dv_out;
  assign in_stall = ~en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r <= op_t'(in_opcode);
      a_r  <= in_operand_a;
      b_r  <= in_operand_b;
    end
  end

  assign prod_nxt = (2*DATA_W)'(a_r) * (2*DATA_W)'(b_r);
  assign mag_a    = a_r[DATA_W-1] ? DATA_W'(-a_r) : a_r;
  assign mag_b    = b_r[DATA_W-1] ? DATA_W'(-b_r) : b_r;
  assign dvd_nxt  = {mag_a, {FRACTION_BITS{1'b0}}};

  always_comb begin
    simple_nxt = '0;
    cmp_nxt    = 1'b0;
    is_mul_nxt = 1'b0;
    is_div_nxt = 1'b0;
    case (op_r)
      OP_ADD:      simple_nxt = a_r + b_r;
      OP_SUB:      simple_nxt = a_r - b_r;
      OP_MUL:      is_mul_nxt = 1'b1;
      OP_DIV:      is_div_nxt = 1'b1;
      OP_GT:       cmp_nxt    = a_r >  b_r;
      OP_LT:       cmp_nxt    = a_r <  b_r;
      OP_GE:       cmp_nxt    = a_r >= b_r;
      OP_LE:       cmp_nxt    = a_r <= b_r;
      OP_EQ:       cmp_nxt    = a_r == b_r;
      OP_NE:       cmp_nxt    = a_r != b_r;
      OP_MIN:      simple_nxt = (a_r < b_r) ? a_r : b_r;
      OP_MAX:      simple_nxt = (a_r > b_r) ? a_r : b_r;
      OP_INC:      simple_nxt = a_r + DATA_W'(1);
      OP_DEC:      simple_nxt = a_r - DATA_W'(1);
      OP_FROM_INT: simple_nxt = a_r << FRACTION_BITS;
      OP_TO_INT:   simple_nxt = a_r >>> FRACTION_BITS;
      default:     simple_nxt = '0;
    endcase
  end

  assign dz_nxt  = is_div_nxt & (b_r == '0);
  assign neg_nxt = a_r[DATA_W-1] ^ b_r[DATA_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_nxt;
      simple_r <= simple_nxt;
      cmp_r    <= cmp_nxt;
      is_mul_r <= is_mul_nxt;
      is_div_r <= is_div_nxt;
      dz_r     <= dz_nxt;
      neg_r    <= neg_nxt;
      dvd_r    <= dvd_nxt;
      dvs_r    <= mag_b;
    end
  end

  // Product scaled back by the fraction width, low word kept.
  always_comb begin
    tag_in.res    = is_mul_r ? prod_r[FRACTION_BITS +: DATA_W] : simple_r;
    tag_in.is_div = is_div_r;
    tag_in.neg    = neg_r;
    tag_in.dz     = dz_r;
    tag_in.cmp    = cmp_r;
  end

  q24alu_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vb_r),
    .dividend  (dvd_r),
    .divisor   (dvs_r),
    .in_tag    (tag_in),
    .out_valid (dv_out),
    .quotient  (quot),
    .out_tag   (tag_out)
  );

  assign q_lo = quot[DATA_W-1:0];

  always_comb begin
    if (!tag_out.is_div) begin
      res_fin = tag_out.res;
    end else if (tag_out.dz) begin
      res_fin = '0;
    end else begin
      res_fin = tag_out.neg ? DATA_W'(-q_lo) : q_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= dv_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && dv_out) begin
      res_r     <= res_fin;
      cmp_out_r <= tag_out.cmp;
      derr_r    <= tag_out.dz;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = res_r;
  assign out_compare_true = cmp_out_r;
  assign out_divide_error = derr_r;

endmodule

// ----- rtl/q24alu_chk.sv -----
// Port-level checker for the Q24.8 ALU, bound to the top level.
`include "q24_8_fixed_point_alu_top_assert.svh"

module q24alu_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [q24alu_pkg::DATA_W-1:0]  out_result_value,
  input logic                                  out_compare_true,
  input logic                                  out_divide_error
);

  // A divide by zero beat carries a zero value and no compare outcome.
  `Q24_ASSERT_IMPLY(a_dz_zero, clk, rst_n, out_valid && out_divide_error, out_result_value == 0 && !out_compare_true)

  // A true comparison always has a zero result value.
  `Q24_ASSERT_IMPLY(a_cmp_zero, clk, rst_n, out_valid && out_compare_true, out_result_value == 0)

  // A stalled result beat stays put with all its fields.
  `Q24_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_result_value) && $stable(out_compare_true) && $stable(out_divide_error))

  // Input is only held off while a result beat sits stalled at the output.
  `Q24_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

endmodule

bind q24_8_fixed_point_alu_top q24alu_chk u_chk (.*);

// ----- tb/tb_q24_8_fixed_point_alu_top.sv -----
// Self-checking testbench for the Q24.8 fixed-point ALU top level.
`timescale 1ns / 100ps

module tb_q24_8_fixed_point_alu_top;
  import q24alu_pkg::*;

  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int PIPE_LAT     = FRAC + 36;
  localparam int SETTLE_CYC   = PIPE_LAT + 20;
  localparam int HOLD_CYC     = 300;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0000_0100;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     cmp;
    logic                     err;
  } alu_beat_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic                     known;
    alu_beat_t                want;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_opcode = '0;
  logic signed [DATA_W-1:0] in_operand_a = '0;
  logic signed [DATA_W-1:0] in_operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_result_value;
  logic out_compare_true;
  logic out_divide_error;

  alu_beat_t expected_beats[$];
  vec_row_t  vec_rows[$];
  int err_count = 0;
  int n_items = 0;
  int n_results = 0;
  int n_div_zero = 0;
  int n_cmp_true = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int unsigned cycles = 0;

  q24_8_fixed_point_alu_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_compare_true (out_compare_true),
    .out_divide_error (out_divide_error)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still pending", cycles,
               expected_beats.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Fixed-point ALU behavior, one result beat per operation.
  function automatic alu_beat_t alu_result(input op_t op, input logic signed [DATA_W-1:0] a,
                                           input logic signed [DATA_W-1:0] b);
    alu_beat_t r;
    longint    wa;
    longint    wb;
    longint    prod;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] quo;
    r  = '0;
    wa = longint'(a);
    wb = longint'(b);
    case (op)
      OP_ADD:      r.val = a + b;
      OP_SUB:      r.val = a - b;
      OP_MUL: begin
        prod  = wa * wb;
        prod  = prod >>> FRAC;
        r.val = prod[DATA_W-1:0];
      end
      OP_DIV: begin
        if (b == 0) begin
          r.err = 1'b1;
        end else begin
          ma  = (wa < 0) ? -wa : wa;
          mb  = (wb < 0) ? -wb : wb;
          quo = (ma << FRAC) / mb;
          if ((wa < 0) != (wb < 0)) quo = -quo;
          r.val = quo[DATA_W-1:0];
        end
      end
      OP_GT:       r.cmp = a > b;
      OP_LT:       r.cmp = a < b;
      OP_GE:       r.cmp = a >= b;
      OP_LE:       r.cmp = a <= b;
      OP_EQ:       r.cmp = a == b;
      OP_NE:       r.cmp = a != b;
      OP_MIN:      r.val = (a < b) ? a : b;
      OP_MAX:      r.val = (a > b) ? a : b;
      OP_INC:      r.val = a + 1;
      OP_DEC:      r.val = a - 1;
      OP_FROM_INT: r.val = a << FRAC;
      default:     r.val = a >>> FRAC;
    endcase
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_operand();
    int s;
    case ($urandom_range(7, 0))
      0: begin
        case ($urandom_range(5, 0))
          0: return '0;
          1: return 32'sd1;
          2: return -32'sd1;
          3: return Q_MIN;
          4: return Q_MAX;
          default: return Q_ONE;
        endcase
      end
      1, 2: begin
        s = int'($urandom_range(4095, 0)) - 2048;
        return s;
      end
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input op_t op, input logic signed [DATA_W-1:0] a,
                         input logic signed [DATA_W-1:0] b, input logic known,
                         input logic signed [DATA_W-1:0] val, input logic cmp,
                         input logic err);
    vec_row_t row;
    row.op    = op;
    row.a     = a;
    row.b     = b;
    row.known = known;
    row.want  = '{val: val, cmp: cmp, err: err};
    vec_rows.push_back(row);
  endtask

  task automatic idle_cycle();
    in_valid     <= 1'b0;
    in_opcode    <= OP_W'($urandom);
    in_operand_a <= $urandom;
    in_operand_b <= $urandom;
    @(posedge clk);
  endtask

  // Hold the beat until the block takes it, then log the expectation.
  task automatic offer(input op_t op, input logic signed [DATA_W-1:0] a,
                       input logic signed [DATA_W-1:0] b, input alu_beat_t want);
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_beats.push_back(want);
    n_items++;
    if (want.err) n_div_zero++;
    if (want.cmp) n_cmp_true++;
  endtask

  task automatic run_random(input int count, input int idle_pct);
    op_t op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    for (int i = 0; i < count; i++) begin
      while (int'($urandom_range(99, 0)) < idle_pct) idle_cycle();
      op = op_t'($urandom_range(15, 0));
      a  = pick_operand();
      b  = pick_operand();
      offer(op, a, b, alu_result(op, a, b));
    end
  endtask

  task automatic drain();
    while (expected_beats.size() != 0) idle_cycle();
    repeat (SETTLE_CYC) idle_cycle();
  endtask

  // Result side: random stall, plus a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= (stall_pct != 0) && (int'($urandom_range(99, 0)) < stall_pct);
    end
  end

  always @(posedge clk) begin
    alu_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: value %h", out_result_value);
        err_count++;
      end else begin
        exp_beat = expected_beats.pop_front();
        if (out_result_value !== exp_beat.val) begin
          $error("result_value expected %h actual %h", exp_beat.val, out_result_value);
          err_count++;
        end
        if (out_compare_true !== exp_beat.cmp) begin
          $error("compare_true expected %b actual %b", exp_beat.cmp, out_compare_true);
          err_count++;
        end
        if (out_divide_error !== exp_beat.err) begin
          $error("divide_error expected %b actual %b", exp_beat.err, out_divide_error);
          err_count++;
        end
      end
    end
  end

  initial begin
    // wrap, extremes, divide by zero, rounding direction, every opcode
    add_row(OP_ADD,      Q_MAX,          32'sd1,         1, Q_MIN,          0, 0);
    add_row(OP_SUB,      Q_MIN,          32'sd1,         1, Q_MAX,          0, 0);
    add_row(OP_MUL,      Q_ONE,          Q_ONE,          1, Q_ONE,          0, 0);
    add_row(OP_MUL,      Q_MIN,          Q_MIN,          1, 32'sd0,         0, 0);
    add_row(OP_MUL,      -32'sd256,      32'sd512,       0, '0,             0, 0);
    add_row(OP_MUL,      Q_MAX,          -32'sd1,        0, '0,             0, 0);
    add_row(OP_DIV,      Q_ONE,          32'sd0,         1, 32'sd0,         0, 1);
    add_row(OP_DIV,      Q_MIN,          32'sd0,         1, 32'sd0,         0, 1);
    add_row(OP_DIV,      Q_MIN,          -32'sd1,        1, 32'sd0,         0, 0);
    add_row(OP_DIV,      Q_MAX,          32'sd1,         1, 32'shFFFF_FF00, 0, 0);
    add_row(OP_DIV,      -32'sh300,      32'sh200,       0, '0,             0, 0);
    add_row(OP_DIV,      -32'sd1,        32'sh200,       0, '0,             0, 0);
    add_row(OP_GT,       Q_MAX,          Q_MIN,          1, 32'sd0,         1, 0);
    add_row(OP_LT,       Q_MIN,          Q_MAX,          1, 32'sd0,         1, 0);
    add_row(OP_GE,       Q_MIN,          Q_MIN,          1, 32'sd0,         1, 0);
    add_row(OP_LE,       Q_MAX,          Q_MIN,          1, 32'sd0,         0, 0);
    add_row(OP_EQ,       Q_MAX,          Q_MAX,          1, 32'sd0,         1, 0);
    add_row(OP_NE,       32'sd5,         32'sd5,         1, 32'sd0,         0, 0);
    add_row(OP_MIN,      Q_MAX,          Q_MIN,          1, Q_MIN,          0, 0);
    add_row(OP_MAX,      Q_MIN,          Q_MAX,          1, Q_MAX,          0, 0);
    add_row(OP_INC,      Q_MAX,          32'sh1234_5678, 1, Q_MIN,          0, 0);
    add_row(OP_DEC,      Q_MIN,          -32'sd1,        1, Q_MAX,          0, 0);
    add_row(OP_FROM_INT, 32'sh00FF_FFFF, Q_MAX,          1, 32'shFFFF_FF00, 0, 0);
    add_row(OP_TO_INT,   -32'sd1,        Q_MIN,          1, -32'sd1,        0, 0);
    add_row(OP_TO_INT,   Q_MIN,          32'sd0,         1, 32'shFF80_0000, 0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vec_rows[i]) begin
      offer(vec_rows[i].op, vec_rows[i].a, vec_rows[i].b,
            vec_rows[i].known ? vec_rows[i].want
                              : alu_result(vec_rows[i].op, vec_rows[i].a, vec_rows[i].b));
    end
    drain();

    stall_pct = 0;
    run_random(350, 0);
    drain();
    stall_pct = 0;
    run_random(350, 59);
    drain();
    stall_pct = 59;
    run_random(350, 0);
    drain();
    stall_pct = 18;
    run_random(350, 18);
    drain();

    // back-pressure: output held off long enough to fill the pipe
    stall_pct = 0;
    hold_req  = 1'b1;
    run_random(150, 0);
    drain();

    if (expected_beats.size() != 0) begin
      $error("%0d expected beats never arrived", expected_beats.size());
      err_count++;
    end
    $display("Ran %0d operations across all 16 opcodes, %0d result beats checked,",
             n_items, n_results);
    $display("including %0d divide-by-zero and %0d true compares under stall and gaps.",
             n_div_zero, n_cmp_true);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
